/* design/adc_spike_canceller_top_macros.svh */
// ----------------------------------------------------------------------------
// ADC spike canceller assertion macros
// Concurrent check wrappers; empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ADC_SPIKE_CANCELLER_TOP_MACROS_SVH
`define ADC_SPIKE_CANCELLER_TOP_MACROS_SVH

`ifndef SYNTH
`define ASC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spike canceller check failed");
`define ASC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spike canceller check failed");
`else
`define ASC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* design/asc_pkg.sv */
// ----------------------------------------------------------------------------
// asc_pkg
// Types and constants shared by the ADC spike canceller modules.
// ----------------------------------------------------------------------------
package asc_pkg;

    typedef logic signed [12:0] sample_t;

    typedef enum logic [1:0] {
        CLS_NOISE = 2'd0,
        CLS_HIGH  = 2'd1,
        CLS_LOW   = 2'd2,
        CLS_OTHER = 2'd3
    } cls_t;

    typedef struct packed {
        sample_t     sample_in;
        logic [1:0]  overload_in;
        logic [4:0]  pad_select;
        logic        channel_select;
    } in_item_t;

    typedef struct packed {
        sample_t     sample_out;
        logic [1:0]  overload_out;
    } out_item_t;

    // per-channel history; index 1 is the newest entry
    typedef struct packed {
        cls_t    [5:1]       cls;
        sample_t [4:1]       samp;
        logic    [4:1][1:0]  ovl;
    } hist_t;

    localparam int HIST_W = $bits(hist_t);

    typedef struct packed {
        logic [2:0]  cancel_level;
        logic [11:0] noise_threshold;
        logic [11:0] spike_amplitude;
    } cfg_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_CANCEL_LEVEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPIKE_AMPLITUDE = 2'd2;

    localparam logic [2:0]  LEVEL_RST = 3'd4;
    localparam logic [11:0] NOISE_RST = 12'd8;
    localparam logic [11:0] AMP_RST   = 12'd150;

endpackage

/* design/adc_spike_canceller_top.sv */
// ----------------------------------------------------------------------------
// adc_spike_canceller_top
// Per-channel ADC spike canceller with history kept in one RAM.
//
//  Port group  Dir  Handshake            Payload
//  in_*        in   in_valid / in_stall   in_data   (asc_pkg::in_item_t)
//  out_*       out  out_valid / out_stall out_data  (asc_pkg::out_item_t)
//  cfg_*       in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; the input transfer
// loads the s1 stage and starts the RAM read, then on advance the
// read-modify-write result goes into the output reg and out_valid rises.
// Back-to-back hits on one channel are served by a write-forward register.
// Reset clears the per-entry valid bits at once, no clearing pass.
// in_stall rises only while the update stage is full and the output is stalled.
// ----------------------------------------------------------------------------
`include "adc_spike_canceller_top_macros.svh"

module adc_spike_canceller_top #(
    parameter int PAD_COUNT      = 32,
    parameter int INPUTS_PER_PAD = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  asc_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output asc_pkg::out_item_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [asc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [asc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DEPTH  = PAD_COUNT * INPUTS_PER_PAD;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    asc_pkg::cfg_t       cfg_reg;
    asc_pkg::cls_t       front_cls;
    logic [ADDR_W-1:0]   front_addr;
    logic                accept_in;
    logic                advance;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [ADDR_W-1:0]   s1_addr_reg;
    asc_pkg::sample_t    s1_x_reg;
    logic [1:0]          s1_ovl_reg;
    asc_pkg::cls_t       s1_cls_reg;
    logic                rd_vld_reg;

    logic [DEPTH-1:0]    vld_reg;
    logic                fwd_valid_reg;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    asc_pkg::hist_t      fwd_data_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    asc_pkg::out_item_t  out_data_reg;

    logic [asc_pkg::HIST_W-1:0] ram_rdata;
    asc_pkg::hist_t      hist_cur;
    asc_pkg::hist_t      hist_new;
    asc_pkg::out_item_t  res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cancel_level    <= asc_pkg::LEVEL_RST;
            cfg_reg.noise_threshold <= asc_pkg::NOISE_RST;
            cfg_reg.spike_amplitude <= asc_pkg::AMP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                asc_pkg::REG_CANCEL_LEVEL:    cfg_reg.cancel_level    <= cfg_data[2:0];
                asc_pkg::REG_NOISE_THRESHOLD: cfg_reg.noise_threshold <= cfg_data;
                asc_pkg::REG_SPIKE_AMPLITUDE: cfg_reg.spike_amplitude <= cfg_data;
                default:                      ;
            endcase
        end
    end

    asc_front #(
        .PAD_COUNT      (PAD_COUNT),
        .INPUTS_PER_PAD (INPUTS_PER_PAD)
    ) u_front (
        .item (in_data),
        .cfg  (cfg_reg),
        .cls  (front_cls),
        .addr (front_addr)
    );

    // pipeline control
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign accept_in = in_valid && !in_stall;

    assign s1_valid_next  = accept_in ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                fwd_valid_reg         <= 1'b1;
                vld_reg[s1_addr_reg]  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_addr_reg <= front_addr;
            s1_x_reg    <= in_data.sample_in;
            s1_ovl_reg  <= in_data.overload_in;
            s1_cls_reg  <= front_cls;
            rd_vld_reg  <= vld_reg[front_addr];
        end
        if (advance)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= hist_new;
            out_data_reg <= res;
        end
    end

    asc_ram #(
        .WIDTH (asc_pkg::HIST_W),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (advance),
        .waddr (s1_addr_reg),
        .wdata (hist_new),
        .re    (accept_in),
        .raddr (front_addr),
        .rdata (ram_rdata)
    );

    // latest write wins; never-written entries read as the reset history
    always_comb
    begin
        priority if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            hist_cur = fwd_data_reg;
        end
        else if (rd_vld_reg)
        begin
            hist_cur = asc_pkg::hist_t'(ram_rdata);
        end
        else
        begin
            hist_cur = '0;
        end
    end

    asc_update u_update (
        .hist_cur (hist_cur),
        .x        (s1_x_reg),
        .xo       (s1_ovl_reg),
        .xc       (s1_cls_reg),
        .level    (cfg_reg.cancel_level),
        .hist_new (hist_new),
        .res      (res)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASC_ASSERT_NXT(a_accept_fills_stage, clk, rst_n, accept_in, s1_valid_reg)
    `ASC_ASSERT_NXT(a_stage_holds, clk, rst_n, s1_valid_reg && out_valid_reg && out_stall, s1_valid_reg && $stable(s1_addr_reg))
    `ASC_ASSERT_NXT(a_write_tracked, clk, rst_n, advance, fwd_valid_reg && vld_reg[fwd_addr_reg] && out_valid_reg)
    `ASC_ASSERT_IMP(a_no_stall_when_free, clk, rst_n, !s1_valid_reg, !in_stall)

endmodule

/* design/asc_ram.sv */
// ----------------------------------------------------------------------------
// asc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module asc_ram #(
    parameter  int WIDTH = 70,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/asc_front.sv */
// ----------------------------------------------------------------------------
// asc_front
// Sample classification and channel history address generation.
// ----------------------------------------------------------------------------
module asc_front #(
    parameter  int PAD_COUNT      = 32,
    parameter  int INPUTS_PER_PAD = 2,
    localparam int DEPTH          = PAD_COUNT * INPUTS_PER_PAD,
    localparam int ADDR_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  asc_pkg::in_item_t  item,
    input  asc_pkg::cfg_t      cfg,
    output asc_pkg::cls_t      cls,
    output logic [ADDR_W-1:0]  addr
);

    logic [12:0] mag;
    logic [6:0]  pad_w;
    logic [6:0]  pad_sat;
    logic [2:0]  ch_w;
    logic [2:0]  ch_sat;
    logic        is_pos;
    logic        is_neg;
    logic        below_amp;

    assign mag = item.sample_in[12] ? 13'(-item.sample_in) : 13'(item.sample_in);
    assign is_neg = item.sample_in[12];
    assign is_pos = !item.sample_in[12] && (item.sample_in != '0);
    // |s| < amp covers both spike signs
    assign below_amp = mag < {1'b0, cfg.spike_amplitude};

    always_comb
    begin
        priority if (mag < {1'b0, cfg.noise_threshold})
        begin
            cls = asc_pkg::CLS_NOISE;
        end
        else if (is_pos && below_amp)
        begin
            cls = asc_pkg::CLS_HIGH;
        end
        else if (is_neg && below_amp)
        begin
            cls = asc_pkg::CLS_LOW;
        end
        else
        begin
            cls = asc_pkg::CLS_OTHER;
        end
    end

    assign pad_w   = 7'(item.pad_select);
    assign pad_sat = (pad_w >= 7'(PAD_COUNT)) ? 7'(PAD_COUNT - 1) : pad_w;
    assign ch_w    = 3'(item.channel_select);
    assign ch_sat  = (ch_w >= 3'(INPUTS_PER_PAD)) ? 3'(INPUTS_PER_PAD - 1) : ch_w;

    assign addr = ADDR_W'(32'(pad_sat) * 32'(INPUTS_PER_PAD) + 32'(ch_sat));

endmodule

/* design/asc_update.sv */
// ----------------------------------------------------------------------------
// asc_update
// Spike run detection, history zeroing and shift for one channel entry.
// ----------------------------------------------------------------------------
module asc_update (
    input  asc_pkg::hist_t     hist_cur,
    input  asc_pkg::sample_t   x,
    input  logic [1:0]         xo,
    input  asc_pkg::cls_t      xc,
    input  logic [2:0]         level,
    output asc_pkg::hist_t     hist_new,
    output asc_pkg::out_item_t res
);

    function automatic logic framed(asc_pkg::cls_t c, asc_pkg::cls_t opp);
        return (c == asc_pkg::CLS_NOISE) || (c == opp);
    endfunction

    // bit 0: output zeroed, bits 1..3: s3, s2, s1 zeroed
    function automatic logic [3:0] run_hits(asc_pkg::hist_t h, asc_pkg::cls_t c_in,
                                            logic [2:0] lvl, asc_pkg::cls_t d,
                                            asc_pkg::cls_t opp);
        logic [3:0] r;
        r = '0;
        if (framed(h.cls[5], opp) && (h.cls[4] == d))
        begin
            if (framed(h.cls[3], opp))
            begin
                r[0] = 1'b1;
            end
            if ((lvl >= 3'd2) && (h.cls[3] == d) && framed(h.cls[2], opp))
            begin
                r[1:0] = 2'b11;
            end
            if ((lvl >= 3'd3) && (h.cls[3] == d) && (h.cls[2] == d)
                && framed(h.cls[1], opp))
            begin
                r[2:0] = 3'b111;
            end
            if ((lvl >= 3'd4) && (h.cls[3] == d) && (h.cls[2] == d)
                && (h.cls[1] == d) && framed(c_in, opp))
            begin
                r = 4'b1111;
            end
        end
        return r;
    endfunction

    logic [3:0]       zero;
    asc_pkg::sample_t s1z;
    asc_pkg::sample_t s2z;
    asc_pkg::sample_t s3z;

    assign zero = run_hits(hist_cur, xc, level, asc_pkg::CLS_HIGH, asc_pkg::CLS_LOW)
                | run_hits(hist_cur, xc, level, asc_pkg::CLS_LOW, asc_pkg::CLS_HIGH);

    assign s3z = zero[1] ? '0 : hist_cur.samp[3];
    assign s2z = zero[2] ? '0 : hist_cur.samp[2];
    assign s1z = zero[3] ? '0 : hist_cur.samp[1];

    always_comb
    begin
        hist_new.cls[5]  = hist_cur.cls[4];
        hist_new.cls[4]  = hist_cur.cls[3];
        hist_new.cls[3]  = hist_cur.cls[2];
        hist_new.cls[2]  = hist_cur.cls[1];
        hist_new.cls[1]  = hist_cur.cls[1];
        hist_new.samp[4] = s3z;
        hist_new.samp[3] = s2z;
        hist_new.samp[2] = s1z;
        hist_new.samp[1] = s1z;
        hist_new.ovl[4]  = hist_cur.ovl[3];
        hist_new.ovl[3]  = hist_cur.ovl[2];
        hist_new.ovl[2]  = hist_cur.ovl[1];
        hist_new.ovl[1]  = hist_cur.ovl[1];
        // insertion point sets the delay
        priority if (level >= 3'd3)
        begin
            hist_new.cls[1]  = xc;
            hist_new.samp[1] = x;
            hist_new.ovl[1]  = xo;
        end
        else if (level >= 3'd2)
        begin
            hist_new.cls[2]  = xc;
            hist_new.samp[2] = x;
            hist_new.ovl[2]  = xo;
        end
        else
        begin
            hist_new.cls[3]  = xc;
            hist_new.samp[3] = x;
            hist_new.ovl[3]  = xo;
        end
    end

    assign res.sample_out   = zero[0] ? '0 : hist_cur.samp[4];
    assign res.overload_out = hist_cur.ovl[4];

endmodule
